// ----- rtl/core/kpdc_pkg.sv -----
package kpdc_pkg;

  // Field widths fixed by the key scan interface
  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register defaults after reset
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TICKS_RST   = 8'd3;
  localparam logic [HOLD_W-1:0]     LONG_TICKS_RST       = 16'd125;
  localparam logic [HOLD_W-1:0]     SUPER_LONG_TICKS_RST = 16'd500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TICKS   = 2'd0,
    CFG_LONG_TICKS       = 2'd1,
    CFG_SUPER_LONG_TICKS = 2'd2
  } cfg_idx_t;

  // Recorded key; zero means no key is recorded
  typedef enum logic [2:0] {
    KEY_NONE  = 3'd0,
    KEY_UP    = 3'd1,
    KEY_DOWN  = 3'd2,
    KEY_ENTER = 3'd3,
    KEY_BACK  = 3'd4
  } held_key_t;

  // Event kinds as they appear on press_kind
  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_SUPER = 2'd2
  } press_kind_t;

  // Key numbers as they appear on key_id
  localparam logic [1:0] KEY_ID_UP    = 2'd0;
  localparam logic [1:0] KEY_ID_DOWN  = 2'd1;
  localparam logic [1:0] KEY_ID_ENTER = 2'd2;
  localparam logic [1:0] KEY_ID_BACK  = 2'd3;

  // One scan tick: active-low key levels
  typedef struct packed {
    logic up_level;
    logic down_level;
    logic enter_level;
    logic back_level;
  } kpdc_in_t;

  // One key event
  typedef struct packed {
    logic [1:0] key_id;
    logic [1:0] press_kind;
  } kpdc_out_t;

  // Thresholds handed from the register block to the classifier
  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [HOLD_W-1:0]     long_ticks;
    logic [HOLD_W-1:0]     super_long_ticks;
  } kpdc_cfg_t;

  // Map a recorded key to its key_id number
  function automatic logic [1:0] key_to_id(held_key_t key);
    logic [1:0] id;
    unique case (key)
      KEY_UP:    id = KEY_ID_UP;
      KEY_DOWN:  id = KEY_ID_DOWN;
      KEY_ENTER: id = KEY_ID_ENTER;
      KEY_BACK:  id = KEY_ID_BACK;
      default:   id = KEY_ID_BACK;
    endcase
    return id;
  endfunction

endpackage

// ----- rtl/core/key_press_duration_classifier.sv -----
// Key press classifier for four active-low keys (up, down, enter, back).
// Each input item is one scan tick; it is registered, classified against the
// debounce, long and super-long thresholds, and any event lands in an output
// register as its tick leaves the input register. One item is taken every
// clock cycle unless the input is stalled. Ticks with no event keep flowing
// while an event waits on a stalled output; the input stalls only when a
// tick's event finds the output register full and stalled. The user must
// write thresholds through the cfg port while no ticks are in flight; the
// block itself does not enforce this.
module key_press_duration_classifier import kpdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kpdc_in_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kpdc_out_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  kpdc_cfg_t cfg;
  logic      s1_valid;
  kpdc_in_t  s1_item;
  logic      emit;
  kpdc_out_t result;
  logic      out_free;
  logic      s1_adv;
  logic      in_accept;

  kpdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpdc_classify u_classify (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (s1_item),
    .step   (s1_adv),
    .emit   (emit),
    .result (result)
  );

  // Move a tick on when it has no event or the output slot is free
  assign out_free  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && (!emit || out_free);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_item;
    end
  end

  // Output register: load an event, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_item <= result;
    end
  end

endmodule

// ----- rtl/core/kpdc_cfg.sv -----
module kpdc_cfg import kpdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output kpdc_cfg_t             cfg
);

  // Write the addressed threshold; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      cfg.long_ticks       <= LONG_TICKS_RST;
      cfg.super_long_ticks <= SUPER_LONG_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= cfg_data[DEBOUNCE_W-1:0];
        CFG_LONG_TICKS:       cfg.long_ticks       <= cfg_data[HOLD_W-1:0];
        CFG_SUPER_LONG_TICKS: cfg.super_long_ticks <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/kpdc_classify.sv -----
module kpdc_classify import kpdc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  kpdc_cfg_t cfg,
  input  kpdc_in_t  item,
  input  logic      step,
  output logic      emit,
  output kpdc_out_t result
);

  logic                  armed;
  logic                  armed_next;
  logic [DEBOUNCE_W-1:0] debounce_count;
  logic [DEBOUNCE_W-1:0] debounce_count_next;
  logic                  press_active;
  logic                  press_active_next;
  logic                  long_seen;
  logic                  long_seen_next;
  logic [HOLD_W-1:0]     hold_count;
  logic [HOLD_W-1:0]     hold_count_next;
  held_key_t             held_key;
  held_key_t             held_key_next;

  logic        up;
  logic        down;
  logic        enter;
  logic        back;
  logic        any;
  held_key_t   emit_key;
  press_kind_t emit_kind;

  assign up    = !item.up_level;
  assign down  = !item.down_level;
  assign enter = !item.enter_level;
  assign back  = !item.back_level;
  assign any   = up || down || enter || back;

  // Work out the next state and the event for the tick at the input register
  always_comb begin
    armed_next          = armed;
    debounce_count_next = debounce_count;
    press_active_next   = press_active;
    long_seen_next      = long_seen;
    hold_count_next     = hold_count;
    held_key_next       = held_key;
    emit                = 1'b0;
    emit_key            = KEY_NONE;
    emit_kind           = KIND_SHORT;

    // Debounce: count ticks with a key down until the press qualifies
    if (armed && any) begin
      if (debounce_count < cfg.debounce_ticks) begin
        debounce_count_next = debounce_count + 1'b1;
      end
      if (debounce_count_next >= cfg.debounce_ticks) begin
        armed_next        = 1'b0;
        press_active_next = 1'b1;
      end
    end

    // Hold: saturate the count, track the key, check the thresholds
    if (press_active_next && any) begin
      if (hold_count != {HOLD_W{1'b1}}) begin
        hold_count_next = hold_count + 1'b1;
      end
      priority if (up)    held_key_next = KEY_UP;
      else if (down)      held_key_next = KEY_DOWN;
      else if (enter)     held_key_next = KEY_ENTER;
      else                held_key_next = KEY_BACK;

      if (hold_count_next >= cfg.long_ticks && !long_seen) begin
        long_seen_next = 1'b1;
        if (held_key_next != KEY_ENTER) begin
          press_active_next = 1'b0;
        end
        emit          = 1'b1;
        emit_key      = held_key_next;
        emit_kind     = KIND_LONG;
        held_key_next = KEY_NONE;
      end

      // Enter only: super-long once the long event has gone out
      if (held_key_next == KEY_ENTER && hold_count_next >= cfg.super_long_ticks &&
          long_seen_next) begin
        long_seen_next    = 1'b0;
        press_active_next = 1'b0;
        emit              = 1'b1;
        emit_key          = held_key_next;
        emit_kind         = KIND_SUPER;
        held_key_next     = KEY_NONE;
      end
    end

    // Release: report a short press if still under the long threshold, then re-arm
    if (!any) begin
      armed_next          = 1'b1;
      debounce_count_next = '0;
      long_seen_next      = 1'b0;
      press_active_next   = 1'b0;
      if (held_key != KEY_NONE && hold_count < cfg.long_ticks) begin
        emit      = 1'b1;
        emit_key  = held_key;
        emit_kind = KIND_SHORT;
      end
      hold_count_next = '0;
      held_key_next   = KEY_NONE;
    end
  end

  assign result.key_id     = key_to_id(emit_key);
  assign result.press_kind = emit_kind;

  // Advance the press state once per tick that leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b1;
      debounce_count <= '0;
      press_active   <= 1'b0;
      long_seen      <= 1'b0;
      hold_count     <= '0;
      held_key       <= KEY_NONE;
    end else if (step) begin
      armed          <= armed_next;
      debounce_count <= debounce_count_next;
      press_active   <= press_active_next;
      long_seen      <= long_seen_next;
      hold_count     <= hold_count_next;
      held_key       <= held_key_next;
    end
  end

endmodule

// ----- rtl/core/kpdc_checker.sv -----
module kpdc_checker import kpdc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input kpdc_out_t out_item
);

  // A stalled event holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("event changed or vanished while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // The input stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room at the output");

  // Super-long events come from the enter key only
  a_super_enter: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.press_kind == KIND_SUPER |-> out_item.key_id == KEY_ID_ENTER)
    else $error("super-long event for a key other than enter");

  // Kind code three is never sent
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.press_kind == KIND_SHORT || out_item.press_kind == KIND_LONG ||
                  out_item.press_kind == KIND_SUPER)
    else $error("undefined press kind on output");

endmodule

bind key_press_duration_classifier kpdc_checker u_kpdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ----- verif/key_event_monitor.sv -----
`timescale 1ns / 100ps

module key_event_monitor import kpdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  kpdc_in_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  kpdc_out_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    events_pending,
  output int                    events_checked
);

  // Threshold copies, tracked from the register write port
  logic [DEBOUNCE_W-1:0] debounce_lim;
  logic [HOLD_W-1:0]     long_lim;
  logic [HOLD_W-1:0]     super_lim;

  // Predicted classifier state
  bit                    armed;
  logic [DEBOUNCE_W-1:0] debounce_cnt;
  bit                    pressing;
  bit                    long_done;
  logic [HOLD_W-1:0]     hold_cnt;
  held_key_t             held;

  // Key events predicted but not yet seen on the output
  kpdc_out_t             key_events[$];
  kpdc_out_t             oldest;

  function automatic void post_event(input held_key_t key, input press_kind_t kind);
    kpdc_out_t ev;
    ev.key_id     = 2'(int'(key) - 1);
    ev.press_kind = kind;
    key_events.push_back(ev);
  endfunction

  // Advance the classifier by one scan tick and queue any event it raises
  function automatic void classify_tick(input kpdc_in_t tick);
    bit up, down, enter, back, any_down;
    up       = !tick.up_level;
    down     = !tick.down_level;
    enter    = !tick.enter_level;
    back     = !tick.back_level;
    any_down = up || down || enter || back;

    // Debounce until the press qualifies
    if (armed && any_down) begin
      if (debounce_cnt < debounce_lim) debounce_cnt = debounce_cnt + 1'b1;
      if (debounce_cnt >= debounce_lim) begin
        armed    = 1'b0;
        pressing = 1'b1;
      end
    end

    // Count hold time, follow the key priority, raise long and super events
    if (pressing && any_down) begin
      if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
      if (up) held = KEY_UP;
      else if (down) held = KEY_DOWN;
      else if (enter) held = KEY_ENTER;
      else held = KEY_BACK;

      if (hold_cnt >= long_lim && !long_done) begin
        long_done = 1'b1;
        if (held != KEY_ENTER) pressing = 1'b0;
        post_event(held, KIND_LONG);
        held = KEY_NONE;
      end

      if (held == KEY_ENTER && hold_cnt >= super_lim && long_done) begin
        long_done = 1'b0;
        pressing  = 1'b0;
        post_event(held, KIND_SUPER);
        held = KEY_NONE;
      end
    end

    // Release: report a short press, then clear and re-arm
    if (!any_down) begin
      armed        = 1'b1;
      debounce_cnt = '0;
      long_done    = 1'b0;
      pressing     = 1'b0;
      if (held != KEY_NONE && hold_cnt < long_lim) post_event(held, KIND_SHORT);
      hold_cnt = '0;
      held     = KEY_NONE;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      debounce_lim   = DEBOUNCE_TICKS_RST;
      long_lim       = LONG_TICKS_RST;
      super_lim      = SUPER_LONG_TICKS_RST;
      armed          = 1'b1;
      debounce_cnt   = '0;
      pressing       = 1'b0;
      long_done      = 1'b0;
      hold_cnt       = '0;
      held           = KEY_NONE;
      fail_count     = 0;
      events_checked = 0;
      key_events.delete();
    end else begin
      // Compare an accepted event with the oldest prediction
      if (out_valid && !out_stall) begin
        if (key_events.size() == 0) begin
          $error("unexpected key event: key_id %0d, press_kind %0d",
                 out_item.key_id, out_item.press_kind);
          fail_count++;
        end else begin
          oldest = key_events.pop_front();
          events_checked++;
          if (out_item.key_id !== oldest.key_id) begin
            $error("key_id mismatch: expected %0d, actual %0d",
                   oldest.key_id, out_item.key_id);
            fail_count++;
          end
          if (out_item.press_kind !== oldest.press_kind) begin
            $error("press_kind mismatch: expected %0d, actual %0d",
                   oldest.press_kind, out_item.press_kind);
            fail_count++;
          end
        end
      end

      // Track threshold writes; other indexes are dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DEBOUNCE_TICKS:   debounce_lim = cfg_data[DEBOUNCE_W-1:0];
          CFG_LONG_TICKS:       long_lim     = cfg_data[HOLD_W-1:0];
          CFG_SUPER_LONG_TICKS: super_lim    = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) classify_tick(in_item);
    end
    events_pending = key_events.size();
  end

endmodule

// ----- verif/tb_key_press_duration_classifier.sv -----
`timescale 1ns / 100ps

module tb_key_press_duration_classifier;
  import kpdc_pkg::*;

  localparam int     CLK_HIGH        = 4;
  localparam int     CLK_LOW         = 4;
  localparam int     DRAIN_CYCLES    = 8;
  localparam int     HOLD_OFF_CYCLES = 80;
  localparam int     RANDOM_TICKS    = 880;
  localparam int     CFG_EVERY       = 150;
  localparam longint LIMIT_NS        = 64'd8_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // Pressed-key masks, one bit per key in item order
  localparam logic [3:0] PRESS_NONE  = 4'b0000;
  localparam logic [3:0] PRESS_UP    = 4'b1000;
  localparam logic [3:0] PRESS_DOWN  = 4'b0100;
  localparam logic [3:0] PRESS_ENTER = 4'b0010;
  localparam logic [3:0] PRESS_BACK  = 4'b0001;
  localparam logic [3:0] PRESS_ALL   = 4'b1111;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  kpdc_in_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  kpdc_out_t             out_item;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int events_pending;
  int events_checked;

  int send_idle_pct;
  int recv_idle_pct;
  int ticks_sent;
  int settings_used;
  int cur_deb;
  int cur_long;
  int cur_super;
  int hold_off_asked;
  int hold_off_done;
  bit in_accepted;

  key_press_duration_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  key_event_monitor event_mon (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .events_pending (events_pending),
    .events_checked (events_checked)
  );

  always begin
    clk = 1'b0;
    #(CLK_LOW);
    clk = 1'b1;
    #(CLK_HIGH);
  end

  // Record input acceptance at the rising edge for the driver
  always @(posedge clk) begin
    in_accepted <= !rst && in_valid && !in_stall;
  end

  // Drive the output stall; serve long hold-offs when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_done != hold_off_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_done++;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Hold a timeout over the whole run
  initial begin
    #(LIMIT_NS);
    $display("key_press_duration_classifier test failed");
    $finish;
  end

  // Offer one scan tick, with a random gap in front, and hold it until taken
  task automatic send_tick(input logic [3:0] pressed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= kpdc_in_t'(~pressed);
    @(negedge clk);
    while (!in_accepted) @(negedge clk);
    ticks_sent++;
  endtask

  task automatic hold_keys(input logic [3:0] pressed, input int n);
    repeat (n) send_tick(pressed);
  endtask

  // Stop offering and wait until the block has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (events_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_thresholds(input int deb, input int lng, input int sup,
                                input bit poke_unused);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_TICKS;
    cfg_data  <= {8'($urandom), 8'(deb)};
    @(negedge clk);
    cfg_index <= CFG_LONG_TICKS;
    cfg_data  <= 16'(lng);
    @(negedge clk);
    cfg_index <= CFG_SUPER_LONG_TICKS;
    cfg_data  <= 16'(sup);
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_IDX_UNUSED;
      cfg_data  <= 16'($urandom);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    cur_deb   = deb & 8'hFF;
    cur_long  = lng & 16'hFFFF;
    cur_super = sup & 16'hFFFF;
    settings_used++;
  endtask

  // Mostly a single key, sometimes a random chord
  function automatic logic [3:0] pick_keys();
    if ($urandom_range(99) < 70) return PRESS_BACK << $urandom_range(0, 3);
    return 4'($urandom_range(1, 15));
  endfunction

  // Press, hold around the thresholds with the odd key change, then release
  task automatic key_sequence();
    logic [3:0] keys;
    int span;
    int len;
    keys = pick_keys();
    span = cur_deb + ((cur_long > cur_super) ? cur_long : cur_super) + 4;
    len  = $urandom_range(1, span);
    repeat (len) begin
      if ($urandom_range(99) < 5) keys = pick_keys();
      send_tick(keys);
    end
    hold_keys(PRESS_NONE, $urandom_range(1, 3));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) send_tick(4'($urandom));
  endtask

  initial begin
    int phase;
    int target;
    int next_cfg;

    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = kpdc_in_t'(~PRESS_NONE);
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_DEBOUNCE_TICKS;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    ticks_sent     = 0;
    settings_used  = 1;
    cur_deb        = DEBOUNCE_TICKS_RST;
    cur_long       = LONG_TICKS_RST;
    cur_super      = SUPER_LONG_TICKS_RST;
    hold_off_asked = 0;
    hold_off_done  = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset thresholds: short up press
    hold_keys(PRESS_UP, 4);
    send_tick(PRESS_NONE);

    // Zero thresholds: enter goes long, then super on the next tick
    set_thresholds(0, 0, 0, 1'b1);
    hold_keys(PRESS_ENTER, 3);
    send_tick(PRESS_NONE);

    // Chord resolves to up, switch to back, long on back
    set_thresholds(2, 3, 5, 1'b0);
    hold_keys(PRESS_ALL, 2);
    hold_keys(PRESS_BACK, 2);
    send_tick(PRESS_NONE);
    // Bounce shorter than debounce
    send_tick(PRESS_DOWN);
    send_tick(PRESS_NONE);
    // Enter long, detour to down, back to enter for super
    hold_keys(PRESS_ENTER, 4);
    hold_keys(PRESS_DOWN, 2);
    send_tick(PRESS_ENTER);
    send_tick(PRESS_NONE);

    // Random sequences under three idle profiles
    next_cfg = ticks_sent;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 30 : 0;
      target = ticks_sent + RANDOM_TICKS / 3;
      while (ticks_sent < target) begin
        if (ticks_sent >= next_cfg) begin
          set_thresholds($urandom_range(0, 6), $urandom_range(0, 20),
                         $urandom_range(0, 40), 1'($urandom));
          next_cfg = ticks_sent + CFG_EVERY;
        end
        if ($urandom_range(9) == 0) noise_burst();
        else key_sequence();
      end
    end

    // Back-pressure: output held off while short presses keep coming
    set_thresholds(1, 3, 3, 1'b0);
    hold_off_asked++;
    repeat (20) begin
      send_tick(PRESS_DOWN);
      send_tick(PRESS_NONE);
    end
    wait_idle();

    // Largest debounce
    set_thresholds(255, 2, 4, 1'b1);
    hold_keys(PRESS_BACK, 100);
    send_tick(PRESS_NONE);
    hold_keys(PRESS_ENTER, 262);
    send_tick(PRESS_NONE);

    // Largest long and super thresholds: enter held well short of them
    set_thresholds(1, 16'hFFFF, 16'hFFFF, 1'b0);
    hold_keys(PRESS_ENTER, 40);
    send_tick(PRESS_NONE);

    // Drain and report
    wait_idle();
    $display("Sent %0d scan ticks under %0d threshold settings;", ticks_sent, settings_used);
    $display("%0d key events compared against the prediction.", events_checked);
    if (fail_count == 0 && events_pending == 0) begin
      $display("key_press_duration_classifier test passed");
    end else begin
      $display("key_press_duration_classifier test failed");
    end
    $finish;
  end

endmodule
